// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset.
`define ZB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ZB_ASSERT_NEVER(name, cond, msg) \
  `ZB_ASSERT(name, !(cond), msg)

`endif

// File: rtl/core/zbdt_pkg.sv
package zbdt_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam int DIM_W     = 9;
  localparam int EXT_W     = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [1:0] ACT_DIRECT = 2'd0;
  localparam logic [1:0] ACT_INTERP = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic signed [31:0] FAR_CODE  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEAR_CODE = 32'sh8000_0000;

  localparam int L2_W   = 25;
  localparam int D2_W   = 27;
  localparam int QUO_W  = D2_W + 32;
  localparam int SQ_W   = QUO_W + (QUO_W % 2);
  localparam int ROOT_W = SQ_W / 2;
  localparam int SREM_W = ROOT_W + 2;
  localparam int PROD_W = 32 + ROOT_W;
  localparam int TERM_W = PROD_W - 16;
  localparam int Z_W    = TERM_W + 2;
  localparam int RN_W   = 33;
  localparam int CNT_W  = $clog2(QUO_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]         action;
    logic               inr;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] depth;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [13:0] qx;
    logic signed [13:0] qy;
    logic signed [31:0] z0;
    logic signed [31:0] z1;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic               interp;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [13:0] qx;
    logic signed [13:0] qy;
    logic signed [31:0] z0;
    logic signed [31:0] z1;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } arith_rsp_t;

endpackage

// File: rtl/core/zbdt_front.sv
module zbdt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [zbdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zbdt_pkg::DIM_W-1:0]     cfg_data,
  input  logic [1:0]                     action,
  input  logic signed [12:0]             px,
  input  logic signed [12:0]             py,
  input  logic signed [31:0]             depth,
  input  logic [11:0]                    start_x,
  input  logic [11:0]                    start_y,
  input  logic signed [31:0]             start_depth,
  input  logic [11:0]                    end_x,
  input  logic [11:0]                    end_y,
  input  logic signed [31:0]             end_depth,
  output zbdt_pkg::cmd_t                 cmd
);
  import zbdt_pkg::*;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [EXT_W-1:0] eff_w;
  logic [EXT_W-1:0] eff_h;
  logic             col_ok;
  logic             row_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(256);
      height_reg <= DIM_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_reg <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      eff_w = EXT_W'(1);
    end else if (EXT_W'(width_reg) > EXT_W'(MAX_WIDTH)) begin
      eff_w = EXT_W'(MAX_WIDTH);
    end else begin
      eff_w = EXT_W'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = EXT_W'(1);
    end else if (EXT_W'(height_reg) > EXT_W'(MAX_HEIGHT)) begin
      eff_h = EXT_W'(MAX_HEIGHT);
    end else begin
      eff_h = EXT_W'(height_reg);
    end
  end

  assign col_ok = !px[12] && (EXT_W'(unsigned'(px)) < eff_w);
  assign row_ok = !py[12] && (EXT_W'(unsigned'(py)) < eff_h);

  always_comb begin
    cmd.action = action;
    cmd.inr    = col_ok && row_ok;
    cmd.idx    = IDX_W'(32'(py[11:0]) * MAX_WIDTH + 32'(px[11:0]));
    cmd.depth  = depth;
    cmd.dx     = 13'(signed'({1'b0, end_x}) - signed'({1'b0, start_x}));
    cmd.dy     = 13'(signed'({1'b0, end_y}) - signed'({1'b0, start_y}));
    cmd.qx     = 14'(signed'({px[12], px}) - signed'({2'b00, start_x}));
    cmd.qy     = 14'(signed'({py[12], py}) - signed'({2'b00, start_y}));
    cmd.z0     = start_depth;
    cmd.z1     = end_depth;
  end

endmodule

// File: rtl/core/zbdt_queue.sv
`include "assert_macros.svh"

module zbdt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  zbdt_pkg::cmd_t push_cmd,
  input  logic           pop,
  output zbdt_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import zbdt_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= bump(wptr);
      end
      if (pop) begin
        rptr <= bump(rptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head  = entries[rptr];
  assign empty = (count == '0);
  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));

  `ZB_ASSERT_NEVER(a_push_when_full, push && full, "transfer into a full queue")
  `ZB_ASSERT_NEVER(a_pop_when_empty, pop && empty, "pop from an empty queue")

endmodule

// File: rtl/core/zbdt_arith.sv
`include "assert_macros.svh"

module zbdt_arith (
  input  logic                 clk,
  input  logic                 rst,
  input  zbdt_pkg::arith_req_t req,
  output zbdt_pkg::arith_rsp_t rsp
);
  import zbdt_pkg::*;

  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001,
    A_SQ   = 8'b0000_0010,
    A_DIV  = 8'b0000_0100,
    A_SQRT = 8'b0000_1000,
    A_MUL  = 8'b0001_0000,
    A_ADD  = 8'b0010_0000,
    A_ZSET = 8'b0100_0000,
    A_RCP  = 8'b1000_0000
  } astate_t;

  astate_t                   state;
  logic [CNT_W-1:0]          cnt;
  logic                      done;
  logic signed [31:0]        result;

  logic signed [12:0]        dx;
  logic signed [12:0]        dy;
  logic signed [13:0]        qx;
  logic signed [13:0]        qy;
  logic signed [31:0]        z0;
  logic signed [31:0]        z1;
  logic [L2_W-1:0]           l2;
  logic [QUO_W-1:0]          num;
  logic [L2_W-1:0]           rem;
  logic [SQ_W-1:0]           sq_val;
  logic [ROOT_W-1:0]         root;
  logic [SREM_W-1:0]         srem;
  logic [31:0]               mag;
  logic                      dneg;
  logic [ROOT_W-1:0]         mr;
  logic [PROD_W-1:0]         acc;
  logic signed [Z_W-1:0]     z;
  logic [Z_W-1:0]            magz;
  logic                      zneg;
  logic [RN_W-1:0]           rnum;
  logic [Z_W-1:0]            rrem;

  logic signed [25:0]        sdx;
  logic signed [25:0]        sdy;
  logic signed [27:0]        sqx;
  logic signed [27:0]        sqy;
  logic [L2_W-1:0]           l2_c;
  logic [D2_W-1:0]           d2_c;
  logic [L2_W:0]             div_trial;
  logic                      div_ge;
  logic [SREM_W+1:0]         sq_rem;
  logic [SREM_W+1:0]         sq_trial;
  logic                      sq_ge;
  logic [ROOT_W-1:0]         root_next;
  logic signed [32:0]        dz;
  logic [TERM_W-1:0]         term;
  logic [Z_W-1:0]            rc_trial;
  logic                      rc_ge;
  logic [RN_W-1:0]           quo;

  always_comb begin
    sdx       = dx * dx;
    sdy       = dy * dy;
    sqx       = qx * qx;
    sqy       = qy * qy;
    l2_c      = L2_W'(unsigned'(sdx)) + L2_W'(unsigned'(sdy));
    d2_c      = D2_W'(unsigned'(sqx)) + D2_W'(unsigned'(sqy));
    div_trial = {rem, num[QUO_W-1]};
    div_ge    = div_trial >= {1'b0, l2};
    sq_rem    = {srem, sq_val[SQ_W-1 -: 2]};
    sq_trial  = (SREM_W + 2)'({root, 2'b01});
    sq_ge     = sq_rem >= sq_trial;
    root_next = {root[ROOT_W-2:0], sq_ge};
    dz        = 33'(z1) - 33'(z0);
    term      = acc[PROD_W-1:16];
    rc_trial  = {rrem[Z_W-2:0], rnum[RN_W-1]};
    rc_ge     = rc_trial >= magz;
    quo       = {rnum[RN_W-2:0], rc_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            dx <= req.dx;
            dy <= req.dy;
            qx <= req.qx;
            qy <= req.qy;
            z0 <= req.z0;
            z1 <= req.z1;
            z  <= Z_W'(req.z0);
            state <= req.interp ? A_SQ : A_ZSET;
          end
        end
        A_SQ: begin
          l2 <= l2_c;
          if (l2_c == '0) begin
            state <= A_ZSET;
          end else begin
            num   <= {d2_c, 32'd0};
            rem   <= '0;
            cnt   <= '0;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          rem <= L2_W'(div_ge ? div_trial - {1'b0, l2} : div_trial);
          num <= {num[QUO_W-2:0], div_ge};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QUO_W - 1)) begin
            sq_val <= SQ_W'({num[QUO_W-2:0], div_ge});
            root   <= '0;
            srem   <= '0;
            cnt    <= '0;
            state  <= A_SQRT;
          end
        end
        A_SQRT: begin
          srem   <= SREM_W'(sq_ge ? sq_rem - sq_trial : sq_rem);
          root   <= root_next;
          sq_val <= sq_val << 2;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            mr    <= root_next;
            mag   <= 32'(dz[32] ? -dz : dz);
            dneg  <= dz[32];
            acc   <= '0;
            cnt   <= '0;
            state <= A_MUL;
          end
        end
        A_MUL: begin
          acc <= (acc << 1) + (mr[ROOT_W-1] ? PROD_W'(mag) : '0);
          mr  <= mr << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            state <= A_ADD;
          end
        end
        A_ADD: begin
          if (dneg) begin
            z <= Z_W'(z0) - signed'({2'b00, term});
          end else begin
            z <= Z_W'(z0) + signed'({2'b00, term});
          end
          state <= A_ZSET;
        end
        A_ZSET: begin
          if (z == '0) begin
            result <= FAR_CODE;
            done   <= 1'b1;
            state  <= A_IDLE;
          end else begin
            zneg  <= z[Z_W-1];
            magz  <= z[Z_W-1] ? unsigned'(-z) : unsigned'(z);
            rnum  <= RN_W'(1) << 32;
            rrem  <= '0;
            cnt   <= '0;
            state <= A_RCP;
          end
        end
        A_RCP: begin
          rrem <= rc_ge ? rc_trial - magz : rc_trial;
          rnum <= quo;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(RN_W - 1)) begin
            if (!zneg) begin
              result <= (quo > RN_W'(32'h7FFF_FFFF)) ? FAR_CODE : signed'(quo[31:0]);
            end else begin
              result <= (quo >= RN_W'(32'h8000_0000)) ? NEAR_CODE : -signed'(quo[31:0]);
            end
            done  <= 1'b1;
            state <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp.done  = done;
  assign rsp.value = result;

  `ZB_ASSERT(a_start_when_idle, req.start |-> (state == A_IDLE), "start while busy")
  `ZB_ASSERT(a_done_returns_idle, done |-> (state == A_IDLE), "result while busy")

endmodule

// File: rtl/core/zbdt_back.sv
`include "assert_macros.svh"

module zbdt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  zbdt_pkg::cmd_t       head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 clearing,
  output zbdt_pkg::arith_req_t req,
  input  zbdt_pkg::arith_rsp_t rsp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 passed,
  output logic                 in_range,
  output logic signed [31:0]   read_depth
);
  import zbdt_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_FIN   = 5'b10000
  } bstate_t;

  bstate_t            state;
  cmd_t               cur;
  logic [IDX_W-1:0]   clr_addr;
  logic signed [31:0] store [STORE_DEPTH];
  logic signed [31:0] mem_rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               res_passed;
  logic signed [31:0] res_rd;
  logic               direct_win;
  logic               interp_win;

  assign pop        = (state == ST_IDLE) && !empty;
  assign clearing   = (state == ST_CLEAR);
  assign direct_win = cur.inr && (cur.action == ACT_DIRECT) && (cur.depth < mem_rdata);
  assign interp_win = rsp.done && (cur.action == ACT_INTERP) && (rsp.value < mem_rdata);

  always_comb begin
    req.start  = (state == ST_LOOK) && cur.inr &&
                 ((cur.action == ACT_INTERP) || (cur.action == ACT_READ));
    req.interp = (cur.action == ACT_INTERP);
    req.dx     = cur.dx;
    req.dy     = cur.dy;
    req.qx     = cur.qx;
    req.qy     = cur.qy;
    req.z0     = (cur.action == ACT_READ) ? mem_rdata : cur.z0;
    req.z1     = cur.z1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.idx;
    mem_wdata = cur.depth;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = FAR_CODE;
      end
      ST_LOOK: mem_we = direct_win;
      ST_CALC: begin
        mem_we    = interp_win;
        mem_wdata = rsp.value;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      mem_rdata <= store[head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            cur   <= head;
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          res_passed <= 1'b0;
          res_rd     <= '0;
          state      <= ST_FIN;
          if (!cur.inr) begin
            res_rd <= (cur.action == ACT_READ) ? FAR_CODE : '0;
          end else begin
            case (cur.action)
              ACT_DIRECT: res_passed <= direct_win;
              ACT_INTERP: state <= ST_CALC;
              ACT_READ:   state <= ST_CALC;
              default:    res_passed <= 1'b0;
            endcase
          end
        end
        ST_CALC: begin
          if (rsp.done) begin
            if (cur.action == ACT_INTERP) begin
              res_passed <= interp_win;
            end else begin
              res_rd <= rsp.value;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            passed     <= res_passed;
            in_range   <= cur.inr;
            read_depth <= res_rd;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ZB_ASSERT(a_rsp_in_calc, rsp.done |-> (state == ST_CALC), "result arrived outside a calculation")
  `ZB_ASSERT_NEVER(a_pop_clearing, pop && clearing, "item taken during the clearing pass")

endmodule

// File: rtl/core/zbuffer_depth_test.sv
// Depth test over a 256 x 256 store of signed Q16.16 reciprocal depths, where the
// smaller value counts as closer. After reset the store is swept to the far code
// 0x7FFFFFFF, one entry a cycle, while in_stall stays high; configuration
// writes are taken throughout. Items are taken into a two-entry queue and
// carried out one at a time, each giving exactly one result transfer. A direct
// test, an out-of-range pixel or an unused action goes through the back end
// without the arithmetic unit; a read adds the reciprocal divider, skipped when
// the stored value is zero; an interpolated test runs the shared bit-serial unit
// through a 59-step divide, a 30-step square root, a 30-step multiply and the
// 33-step reciprocal in turn, with the first three skipped for a zero-length
// line.
module zbuffer_depth_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [zbdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zbdt_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic signed [12:0]             px,
  input  logic signed [12:0]             py,
  input  logic signed [31:0]             depth,
  input  logic [11:0]                    start_x,
  input  logic [11:0]                    start_y,
  input  logic signed [31:0]             start_depth,
  input  logic [11:0]                    end_x,
  input  logic [11:0]                    end_y,
  input  logic signed [31:0]             end_depth,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           passed,
  output logic                           in_range,
  output logic signed [31:0]             read_depth
);
  import zbdt_pkg::*;

  cmd_t       front_cmd;
  cmd_t       head;
  logic       q_empty;
  logic       q_full;
  logic       pop;
  logic       clearing;
  logic       push;
  arith_req_t req;
  arith_rsp_t rsp;

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  zbdt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .px          (px),
    .py          (py),
    .depth       (depth),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_depth (start_depth),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_depth   (end_depth),
    .cmd         (front_cmd)
  );

  zbdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  zbdt_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  zbdt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .clearing   (clearing),
    .req        (req),
    .rsp        (rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .passed     (passed),
    .in_range   (in_range),
    .read_depth (read_depth)
  );

endmodule
